@@ sv/fxa_pkg.sv @@
// shared types and constants for the fixed-point alu
// no dependencies
package fxa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;  // width of the scaled dividend

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } t_op;

    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic [DATA_W-1:0] res;
        logic              cmp;
        logic              dz;
        logic              neg;
        logic [DATA_W-1:0] rem;
        logic [NUM_W-1:0]  dvd;
        logic [NUM_W-1:0]  quo;
        logic [DATA_W-1:0] dsr;
    } t_item;

endpackage

@@ sv/fxa_front.sv @@
// operand decode stage: simple results, full product, divider setup
// depends on fxa_pkg
module fxa_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [3:0]                          i_opcode,
    input  logic signed [fxa_pkg::DATA_W-1:0]   i_operand_a,
    input  logic signed [fxa_pkg::DATA_W-1:0]   i_operand_b,
    output fxa_pkg::t_item                      o_item,
    output logic                                o_is_mul,
    output logic signed [2*fxa_pkg::DATA_W-1:0] o_prod
);

    fxa_pkg::t_item                      r_item, n_item;
    logic                                r_is_mul;
    logic signed [2*fxa_pkg::DATA_W-1:0] r_prod;
    logic [fxa_pkg::DATA_W-1:0]          abs_a, abs_b;
    fxa_pkg::t_op                        op;

    assign op    = fxa_pkg::t_op'(i_opcode);
    assign abs_a = i_operand_a[fxa_pkg::DATA_W-1] ? -i_operand_a : i_operand_a;
    assign abs_b = i_operand_b[fxa_pkg::DATA_W-1] ? -i_operand_b : i_operand_b;

    always_comb begin
        n_item        = '0;
        n_item.valid  = i_valid;
        n_item.is_div = (op == fxa_pkg::OP_DIV);
        n_item.neg    = i_operand_a[fxa_pkg::DATA_W-1] ^ i_operand_b[fxa_pkg::DATA_W-1];
        n_item.dvd    = {abs_a, {fxa_pkg::FRAC_BITS{1'b0}}};
        n_item.dsr    = abs_b;
        case (op)
            fxa_pkg::OP_ADD:      n_item.res = i_operand_a + i_operand_b;
            fxa_pkg::OP_SUB:      n_item.res = i_operand_a - i_operand_b;
            fxa_pkg::OP_DIV:      n_item.dz  = (i_operand_b == '0);
            fxa_pkg::OP_GT:       n_item.cmp = i_operand_a >  i_operand_b;
            fxa_pkg::OP_LT:       n_item.cmp = i_operand_a <  i_operand_b;
            fxa_pkg::OP_GE:       n_item.cmp = i_operand_a >= i_operand_b;
            fxa_pkg::OP_LE:       n_item.cmp = i_operand_a <= i_operand_b;
            fxa_pkg::OP_EQ:       n_item.cmp = i_operand_a == i_operand_b;
            fxa_pkg::OP_NE:       n_item.cmp = i_operand_a != i_operand_b;
            fxa_pkg::OP_MIN:      n_item.res = (i_operand_a < i_operand_b) ? i_operand_a
                                                                           : i_operand_b;
            fxa_pkg::OP_MAX:      n_item.res = (i_operand_a > i_operand_b) ? i_operand_a
                                                                           : i_operand_b;
            fxa_pkg::OP_INC:      n_item.res = i_operand_a + 1'b1;
            fxa_pkg::OP_DEC:      n_item.res = i_operand_a - 1'b1;
            fxa_pkg::OP_FROM_INT: n_item.res = i_operand_a << fxa_pkg::FRAC_BITS;
            fxa_pkg::OP_TO_INT:   n_item.res = i_operand_a >>> fxa_pkg::FRAC_BITS;
            default:              n_item.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item   <= n_item;
            r_is_mul <= (op == fxa_pkg::OP_MUL);
            r_prod   <= i_operand_a * i_operand_b;
        end
    end

    assign o_item   = r_item;
    assign o_is_mul = r_is_mul;
    assign o_prod   = r_prod;

endmodule

@@ sv/fxa_div_cell.sv @@
// one restoring-division cell: one quotient bit per cell, word passed on each cycle while i_en is high
// depends on fxa_pkg
module fxa_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  fxa_pkg::t_item i_item,
    output fxa_pkg::t_item o_item
);

    fxa_pkg::t_item             r_item, n_item;
    logic [fxa_pkg::DATA_W:0]   rem_sh, diff;

    assign rem_sh = {i_item.rem, i_item.dvd[fxa_pkg::NUM_W-1]};
    assign diff   = rem_sh - {1'b0, i_item.dsr};

    always_comb begin
        n_item     = i_item;
        n_item.dvd = {i_item.dvd[fxa_pkg::NUM_W-2:0], 1'b0};
        // remainder stays below the divisor, so it fits the low bits
        n_item.rem = diff[fxa_pkg::DATA_W] ? rem_sh[fxa_pkg::DATA_W-1:0]
                                           : diff[fxa_pkg::DATA_W-1:0];
        n_item.quo = {i_item.quo[fxa_pkg::NUM_W-2:0], ~diff[fxa_pkg::DATA_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

@@ sv/fixed_point_alu.sv @@
// fixed-point alu, signed 32-bit raw words with FRAC_BITS fractional bits
// pipeline: registered front stage, one divider cell per quotient bit, then the output register
// throughput: one word per cycle; the whole pipe holds while the output word is stalled
// reset (synchronous, active low) clears all valid bits; no other state
// depends on fxa_pkg, fxa_front, fxa_div_cell
module fixed_point_alu (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [3:0]                        i_opcode,
    input  logic signed [fxa_pkg::DATA_W-1:0] i_operand_a,
    input  logic signed [fxa_pkg::DATA_W-1:0] i_operand_b,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [fxa_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_compare_true,
    output logic                              o_divide_by_zero
);

    logic                                en;
    fxa_pkg::t_item                      front_item, cell0_in;
    logic                                front_is_mul;
    logic signed [2*fxa_pkg::DATA_W-1:0] front_prod, prod_sh;
    fxa_pkg::t_item                      chain [fxa_pkg::NUM_W+1];
    fxa_pkg::t_item                      last;
    logic [fxa_pkg::DATA_W-1:0]          q, n_res;
    logic                                r_valid, r_cmp, r_dz;
    logic [fxa_pkg::DATA_W-1:0]          r_res;

    assign en      = !(r_valid && i_stall);
    assign o_stall = r_valid && i_stall;

    fxa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_opcode    (i_opcode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_item      (front_item),
        .o_is_mul    (front_is_mul),
        .o_prod      (front_prod)
    );

    assign prod_sh = front_prod >>> fxa_pkg::FRAC_BITS;

    always_comb begin
        cell0_in = front_item;
        if (front_is_mul) begin
            cell0_in.res = prod_sh[fxa_pkg::DATA_W-1:0];
        end
    end

    assign chain[0] = cell0_in;

    for (genvar g = 0; g < fxa_pkg::NUM_W; g++) begin : g_cell
        fxa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (chain[g]),
            .o_item  (chain[g+1])
        );
    end

    assign last = chain[fxa_pkg::NUM_W];
    // quotient wraps to the word width
    assign q    = last.quo[fxa_pkg::DATA_W-1:0];

    always_comb begin
        n_res = last.res;
        if (last.is_div && !last.dz) begin
            n_res = last.neg ? -q : q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= last.valid;
            r_res   <= n_res;
            r_cmp   <= last.cmp;
            r_dz    <= last.dz;
        end
    end

    assign o_valid          = r_valid;
    assign o_result_value   = r_res;
    assign o_compare_true   = r_cmp;
    assign o_divide_by_zero = r_dz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_dz) |-> (r_res == '0))
        else $error("divide by zero word carries a nonzero result");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_cmp) |-> (r_res == '0 && !r_dz))
        else $error("comparison word carries a result or zero flag");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_res) && $stable(chain[1])))
        else $error("pipe moved while the output word was stalled");

endmodule
